>>> sv/mts_pkg.sv
// ----------------------------------------------------------------------------
// mts_pkg
// Shared constants and types for the min-tracking stack: field widths,
// operation codes and the controller/datapath command and status words.
// ----------------------------------------------------------------------------
`default_nettype none

package mts_pkg;

  // fixed widths of the channel fields
  localparam int FIELD_W = 32;
  localparam int OP_W    = 2;

  // defaults for the top-level parameters
  localparam int DEF_DEPTH       = 256;
  localparam int DEF_VALUE_WIDTH = 32;

  // operation codes; the unused code behaves as a peek
  localparam logic [OP_W-1:0] OP_PUSH = 2'd0;
  localparam logic [OP_W-1:0] OP_POP  = 2'd1;
  localparam logic [OP_W-1:0] OP_PEEK = 2'd2;

  // controller to datapath
  typedef struct packed {
    logic exec;      // run the accepted word against the stack
    logic load_top;  // reload top registers from the store read data
    logic emit;      // capture the result into the output register
  } mts_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic need_fetch;  // pending pop leaves an entry that lives in the store
  } mts_sts_t;

endpackage

`default_nettype wire

>>> sv/mts_if.sv
// ----------------------------------------------------------------------------
// mts_if
// Valid/ready channel interfaces of the min-tracking stack: the operation
// channel and the result channel.
// ----------------------------------------------------------------------------
`default_nettype none

interface mts_in_if;
  logic                                valid;
  logic                                ready;
  logic [mts_pkg::OP_W-1:0]            operation;
  logic signed [mts_pkg::FIELD_W-1:0]  push_value;

  modport source (output valid, output operation, output push_value, input ready);
  modport sink   (input valid, input operation, input push_value, output ready);
endinterface

interface mts_out_if;
  logic                                valid;
  logic                                ready;
  logic signed [mts_pkg::FIELD_W-1:0]  data_value;
  logic signed [mts_pkg::FIELD_W-1:0]  current_min;
  logic                                is_empty;
  logic                                is_full;
  logic                                underflow;
  logic                                overflow;

  modport source (output valid, output data_value, output current_min, output is_empty,
                  output is_full, output underflow, output overflow, input ready);
  modport sink   (input valid, input data_value, input current_min, input is_empty,
                  input is_full, input underflow, input overflow, output ready);
endinterface

`default_nettype wire

>>> sv/mts_ram.sv
// ----------------------------------------------------------------------------
// mts_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module mts_ram #(
  parameter int WIDTH = mts_pkg::DEF_VALUE_WIDTH,
  parameter int DEPTH = mts_pkg::DEF_DEPTH
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem_r[raddr];
    end
  end

endmodule

`default_nettype wire

>>> sv/mts_ctrl.sv
// ----------------------------------------------------------------------------
// mts_ctrl
// Sequencer of the min-tracking stack: takes one word, waits out the store
// read on a deep pop, then hands the result to the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module mts_ctrl (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire logic              out_ready,
  output logic                   out_valid,
  input  wire mts_pkg::mts_sts_t sts,
  output mts_pkg::mts_cmd_t      cmd
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_FETCH,
    S_EMIT
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   slot_free;

  assign slot_free = !out_valid_r || out_ready;

  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r && !out_ready;
    cmd           = '0;
    in_ready      = 1'b0;
    case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.exec  = 1'b1;
          state_nxt = sts.need_fetch ? S_FETCH : S_EMIT;
        end
      end
      S_FETCH: begin
        cmd.load_top = 1'b1;
        state_nxt    = S_EMIT;
      end
      S_EMIT: begin
        if (slot_free) begin
          cmd.emit      = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

endmodule

`default_nettype wire

>>> sv/mts_dpath.sv
// ----------------------------------------------------------------------------
// mts_dpath
// Datapath of the min-tracking stack: entry count, top entry and its running
// minimum in registers, lower entries in two RAMs, result register.
// ----------------------------------------------------------------------------
`default_nettype none

module mts_dpath #(
  parameter int DEPTH       = mts_pkg::DEF_DEPTH,
  parameter int VALUE_WIDTH = mts_pkg::DEF_VALUE_WIDTH
) (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire mts_pkg::mts_cmd_t                  cmd,
  output mts_pkg::mts_sts_t                       sts,
  input  wire logic [mts_pkg::OP_W-1:0]           in_operation,
  input  wire logic signed [mts_pkg::FIELD_W-1:0] in_push_value,
  output logic signed [mts_pkg::FIELD_W-1:0]      out_data_value,
  output logic signed [mts_pkg::FIELD_W-1:0]      out_current_min,
  output logic                                    out_is_empty,
  output logic                                    out_is_full,
  output logic                                    out_underflow,
  output logic                                    out_overflow
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam int VW = VALUE_WIDTH;
  localparam int FW = mts_pkg::FIELD_W;
  localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

  logic [CW-1:0]          count_r, count_nxt;
  logic signed [VW-1:0]   top_val_r, top_val_nxt;
  logic signed [VW-1:0]   top_min_r, top_min_nxt;
  logic signed [VW-1:0]   pop_val_r, pop_val_nxt;
  logic                   popped_r, popped_nxt;
  logic                   under_r, under_nxt;
  logic                   over_r, over_nxt;

  logic [CW-1:0]          cnt_m1, cnt_m2;
  logic                   is_push, is_pop, empty, full;
  logic signed [VW-1:0]   push_v, new_min;
  logic                   ram_we, ram_re;
  logic [VW-1:0]          rd_val, rd_min;

  assign cnt_m1  = count_r - CW'(1);
  assign cnt_m2  = count_r - CW'(2);
  assign is_push = (in_operation == mts_pkg::OP_PUSH);
  assign is_pop  = (in_operation == mts_pkg::OP_POP);
  assign empty   = (count_r == '0);
  assign full    = (count_r == FULL_CNT);
  assign push_v  = VW'(in_push_value);

  // new entry's minimum against the one below it
  assign new_min = (!empty && (top_min_r < push_v)) ? top_min_r : push_v;

  assign sts.need_fetch = is_pop && (count_r > CW'(1));

  // old top spills into the store when a push lands on a non-empty, non-full stack
  assign ram_we = cmd.exec && is_push && !empty && !full;
  assign ram_re = cmd.exec && sts.need_fetch;

  mts_ram #(.WIDTH(VW), .DEPTH(DEPTH)) u_value_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (cnt_m1[AW-1:0]),
    .wdata (top_val_r),
    .re    (ram_re),
    .raddr (cnt_m2[AW-1:0]),
    .rdata (rd_val)
  );

  mts_ram #(.WIDTH(VW), .DEPTH(DEPTH)) u_min_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (cnt_m1[AW-1:0]),
    .wdata (top_min_r),
    .re    (ram_re),
    .raddr (cnt_m2[AW-1:0]),
    .rdata (rd_min)
  );

  always_comb begin
    count_nxt   = count_r;
    top_val_nxt = top_val_r;
    top_min_nxt = top_min_r;
    pop_val_nxt = pop_val_r;
    popped_nxt  = popped_r;
    under_nxt   = under_r;
    over_nxt    = over_r;
    if (cmd.exec) begin
      popped_nxt = 1'b0;
      under_nxt  = 1'b0;
      over_nxt   = 1'b0;
      case (in_operation)
        mts_pkg::OP_PUSH: begin
          if (full) begin
            over_nxt = 1'b1;
          end else begin
            top_val_nxt = push_v;
            top_min_nxt = new_min;
            count_nxt   = count_r + CW'(1);
          end
        end
        mts_pkg::OP_POP: begin
          if (empty) begin
            under_nxt = 1'b1;
          end else begin
            popped_nxt  = 1'b1;
            pop_val_nxt = top_val_r;
            count_nxt   = cnt_m1;
          end
        end
        default: begin
        end
      endcase
    end
    if (cmd.load_top) begin
      top_val_nxt = $signed(rd_val);
      top_min_nxt = $signed(rd_min);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else begin
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    top_val_r <= top_val_nxt;
    top_min_r <= top_min_nxt;
    pop_val_r <= pop_val_nxt;
    popped_r  <= popped_nxt;
    under_r   <= under_nxt;
    over_r    <= over_nxt;
  end

  // result register
  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      if (popped_r) begin
        out_data_value <= FW'(pop_val_r);
      end else if (empty) begin
        out_data_value <= '1;
      end else begin
        out_data_value <= FW'(top_val_r);
      end
      out_current_min <= empty ? '1 : FW'(top_min_r);
      out_is_empty    <= empty;
      out_is_full     <= full;
      out_underflow   <= under_r;
      out_overflow    <= over_r;
    end
  end

endmodule

`default_nettype wire

>>> sv/min_tracking_stack.sv
// ----------------------------------------------------------------------------
// min_tracking_stack
// Stack of signed values that tracks the minimum of each entry and all
// entries below it; push, pop and peek, one result word per operation.
// ----------------------------------------------------------------------------
//
//   channel  dir  handshake      payload
//   in_ch    in   valid/ready    operation, push_value
//   out_ch   out  valid/ready    data_value, current_min, is_empty, is_full,
//                                underflow, overflow
//
// push, peek and pops that empty the stack or find it empty pass S_IDLE, S_EMIT;
// a pop that leaves entries also passes S_FETCH, for the registered read of
// the lower-entry RAMs (top entry lives in registers).
// a word is accepted while the previous result still waits; the next result
// holds until the output register is taken.
// rst_n is synchronous; reset empties the stack, RAM contents are not cleared.
// ----------------------------------------------------------------------------
`default_nettype none

module min_tracking_stack #(
  parameter int DEPTH       = mts_pkg::DEF_DEPTH,
  parameter int VALUE_WIDTH = mts_pkg::DEF_VALUE_WIDTH
) (
  input wire logic  clk,
  input wire logic  rst_n,
  mts_in_if.sink    in_ch,
  mts_out_if.source out_ch
);

  mts_pkg::mts_cmd_t cmd;
  mts_pkg::mts_sts_t sts;

  logic signed [mts_pkg::FIELD_W-1:0] data_value;
  logic signed [mts_pkg::FIELD_W-1:0] current_min;
  logic in_ready, out_valid, is_empty, is_full, underflow, overflow;

  mts_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ready),
    .out_ready (out_ch.ready),
    .out_valid (out_valid),
    .sts       (sts),
    .cmd       (cmd)
  );

  mts_dpath #(.DEPTH(DEPTH), .VALUE_WIDTH(VALUE_WIDTH)) u_dpath (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .sts             (sts),
    .in_operation    (in_ch.operation),
    .in_push_value   (in_ch.push_value),
    .out_data_value  (data_value),
    .out_current_min (current_min),
    .out_is_empty    (is_empty),
    .out_is_full     (is_full),
    .out_underflow   (underflow),
    .out_overflow    (overflow)
  );

  assign in_ch.ready        = in_ready;
  assign out_ch.valid       = out_valid;
  assign out_ch.data_value  = data_value;
  assign out_ch.current_min = current_min;
  assign out_ch.is_empty    = is_empty;
  assign out_ch.is_full     = is_full;
  assign out_ch.underflow   = underflow;
  assign out_ch.overflow    = overflow;

endmodule

`default_nettype wire
